// ===== rtl/cids_pkg.sv =====
// Shared types and constants for the code image disparity search block.
// No dependencies; compiled before every other file of the block.
package cids_pkg;

  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int DX_W       = 9;
  localparam int DY_W       = 7;
  localparam int IW_W       = 11;
  localparam int IH_W       = 10;
  localparam int DISPX_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  // signed pixel position, wide enough for col + 511 and MAX_WIDTH = 4096
  localparam int POS_W      = 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_NEG = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DX_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DX_MAX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DY_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DY_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H      = 3'd6;

  // request types
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_MATCH = 1'b1;

  // squared distance limit, 1.0 in Q.8
  localparam int MATCH_LIMIT = 256;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } cids_state_t;

endpackage

// ===== rtl/cids_in_if.sv =====
// Input channel of the disparity search: valid/ready plus one request item.
// Depends on cids_pkg for field widths.
interface cids_in_if
  import cids_pkg::*;
#(
  parameter int CODE_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;
  logic signed [CODE_BITS-1:0] code_x;
  logic signed [CODE_BITS-1:0] code_y;

  modport source (output valid, req_type, col, row, code_x, code_y, input ready);
  modport sink   (input valid, req_type, col, row, code_x, code_y, output ready);
endinterface

// ===== rtl/cids_out_if.sv =====
// Result channel of the disparity search: valid/ready plus one result item.
// Depends on cids_pkg for field widths.
interface cids_out_if
  import cids_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [DISPX_W-1:0] disp_x;
  logic signed [DY_W-1:0]    disp_y;
  logic                      matched;

  modport source (output valid, disp_x, disp_y, matched, input ready);
  modport sink   (input valid, disp_x, disp_y, matched, output ready);
endinterface

// ===== rtl/cids_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/code_image_disparity_search.sv =====
// Structured-light code correspondence search. Load items (req_type 0) write
// one target code pair into a MAX_WIDTH x MAX_HEIGHT RAM; they return
// nothing. Match items (req_type 1) scan the window
// dy_min..dy_max by dx_min..dx_max-1 and return one result item: the first
// candidate with the least squared code distance, reported when that distance
// is at most 1.0 (256 in Q.8). The scan steps through one candidate per
// cycle and issues a RAM read only for candidates inside the image; after the
// last candidate the pipeline drains, the result is handed off and the block
// returns to idle before the next item is taken. A negative code, a source
// pixel outside the image or an empty window skip the scan. A receiver that
// still holds the previous result stalls the hand-off. The next item is
// accepted in the cycle after the previous result enters the output
// register. The target store is not cleared at reset: reading a pixel never
// loaded gives arbitrary data. Configuration must be written only while
// idle, by the user; the block itself does not enforce it.
module code_image_disparity_search
  import cids_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int CODE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cids_in_if.sink               in_ch,
  cids_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SQ_W   = 2 * CODE_BITS + 1;  // square of a (CODE_BITS+1)-bit diff
  localparam int DIST_W = SQ_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                   search_neg_r;
  logic [DX_W-1:0]        dx_min_r, dx_max_r;
  logic signed [DY_W-1:0] dy_min_r, dy_max_r;
  logic [IW_W-1:0]        img_w_r;
  logic [IH_W-1:0]        img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_neg_r <= 1'b1;
      dx_min_r     <= '0;
      dx_max_r     <= DX_W'(64);
      dy_min_r     <= -DY_W'(1);
      dy_max_r     <= DY_W'(1);
      img_w_r      <= IW_W'(1024);
      img_h_r      <= IH_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SEARCH_NEG: search_neg_r <= cfg_wdata[0];
        REG_DX_MIN:     dx_min_r     <= cfg_wdata[DX_W-1:0];
        REG_DX_MAX:     dx_max_r     <= cfg_wdata[DX_W-1:0];
        REG_DY_MIN:     dy_min_r     <= cfg_wdata[DY_W-1:0];
        REG_DY_MAX:     dy_max_r     <= cfg_wdata[DY_W-1:0];
        REG_IMG_W:      img_w_r      <= cfg_wdata[IW_W-1:0];
        REG_IMG_H:      img_h_r      <= cfg_wdata[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // image size clamped to the store
  logic [POS_W-1:0] lim_w, lim_h;
  always_comb begin
    lim_w = POS_W'(img_w_r);
    if (POS_W'(img_w_r) > POS_W'(MAX_WIDTH)) lim_w = POS_W'(MAX_WIDTH);
    lim_h = POS_W'(img_h_r);
    if (POS_W'(img_h_r) > POS_W'(MAX_HEIGHT)) lim_h = POS_W'(MAX_HEIGHT);
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  cids_state_t state_r, state_nxt;
  logic        in_rdy, scan_en, done_en, out_fire;
  logic        acc, acc_match, acc_load, skip_scan, last_cand;
  logic        p1_vld_r, p2_vld_r;
  logic        out_vld_r, out_vld_nxt;

  assign acc       = in_ch.valid && in_rdy;
  assign acc_match = acc && (in_ch.req_type == REQ_MATCH);
  assign acc_load  = acc && (in_ch.req_type == REQ_LOAD);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (acc_match) state_nxt = skip_scan ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (last_cand) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!p1_vld_r && !p2_vld_r) state_nxt = ST_DONE;
      ST_DONE:  if (!out_vld_r || out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_rdy  = 1'b0;
    scan_en = 1'b0;
    done_en = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_rdy  = 1'b1;
      ST_SCAN:  scan_en = 1'b1;
      ST_FLUSH: ;
      ST_DONE:  done_en = 1'b1;
      default: ;
    endcase
  end

  assign out_fire = done_en && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Source latch and window counters
  // ---------------------------------------------------------------------------
  logic [COL_W-1:0]            src_col_r, src_col_nxt;
  logic [ROW_W-1:0]            src_row_r, src_row_nxt;
  logic signed [CODE_BITS-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [DY_W-1:0]      y_r, y_nxt;
  logic [DX_W-1:0]             m_r, m_nxt;
  logic                        m_wrap;

  // early out: negative code, source off the image, or empty window
  assign skip_scan = in_ch.code_x[CODE_BITS-1] || in_ch.code_y[CODE_BITS-1]
                  || (POS_W'(in_ch.col) >= lim_w) || (POS_W'(in_ch.row) >= lim_h)
                  || (dx_min_r >= dx_max_r) || (dy_min_r > dy_max_r);

  assign m_wrap    = ({1'b0, m_r} + (DX_W+1)'(1)) == {1'b0, dx_max_r};
  assign last_cand = m_wrap && (y_r == dy_max_r);

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    y_nxt       = y_r;
    m_nxt       = m_r;
    if (acc_match) begin
      src_col_nxt = in_ch.col;
      src_row_nxt = in_ch.row;
      sx_nxt      = in_ch.code_x;
      sy_nxt      = in_ch.code_y;
      y_nxt       = dy_min_r;
      m_nxt       = dx_min_r;
    end else if (scan_en) begin
      if (m_wrap) begin
        m_nxt = dx_min_r;
        y_nxt = y_r + DY_W'(1);
      end else begin
        m_nxt = m_r + DX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    src_col_r <= src_col_nxt;
    src_row_r <= src_row_nxt;
    sx_r      <= sx_nxt;
    sy_r      <= sy_nxt;
    y_r       <= y_nxt;
    m_r       <= m_nxt;
  end

  // ---------------------------------------------------------------------------
  // Candidate position and target store
  // ---------------------------------------------------------------------------
  logic signed [POS_W-1:0]    cand_r_pos, cand_c_pos;
  logic signed [DISPX_W-1:0]  cand_d;
  logic                       cand_ok;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       wr_en;
  logic [2*CODE_BITS-1:0]     rd_data;

  always_comb begin
    cand_d     = search_neg_r ? -DISPX_W'(m_r) : DISPX_W'(m_r);
    cand_r_pos = $signed(POS_W'(src_row_r)) + POS_W'(y_r);
    cand_c_pos = $signed(POS_W'(src_col_r)) + POS_W'(cand_d);
    cand_ok    = !cand_r_pos[POS_W-1] && ($unsigned(cand_r_pos) < lim_h)
              && !cand_c_pos[POS_W-1] && ($unsigned(cand_c_pos) < lim_w);
    rd_addr    = ADDR_W'($unsigned(cand_r_pos)) * ADDR_W'(MAX_WIDTH)
               + ADDR_W'($unsigned(cand_c_pos));
  end

  // loads beyond the store are dropped
  assign wr_en   = acc_load && (POS_W'(in_ch.col) < POS_W'(MAX_WIDTH))
                            && (POS_W'(in_ch.row) < POS_W'(MAX_HEIGHT));
  assign wr_addr = ADDR_W'(in_ch.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_ch.col);

  cids_ram #(
    .WIDTH (2 * CODE_BITS),
    .DEPTH (DEPTH)
  ) u_target_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({in_ch.code_y, in_ch.code_x}),
    .re    (scan_en && cand_ok),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Distance pipeline: p1 = RAM data out, p2 = squares, then best update
  // ---------------------------------------------------------------------------
  logic signed [DISPX_W-1:0]     p1_d_r, p2_d_r;
  logic signed [DY_W-1:0]        p1_y_r, p2_y_r;
  logic signed [CODE_BITS-1:0]   tcx, tcy;
  logic signed [CODE_BITS:0]     ex, ey;
  logic signed [2*CODE_BITS+1:0] prod_x, prod_y;
  logic [SQ_W-1:0]               p2_sqx_r, p2_sqy_r;
  logic [DIST_W-1:0]             cand_dist;

  assign tcx       = rd_data[CODE_BITS-1:0];
  assign tcy       = rd_data[2*CODE_BITS-1:CODE_BITS];
  assign ex        = (CODE_BITS+1)'(sx_r) - (CODE_BITS+1)'(tcx);
  assign ey        = (CODE_BITS+1)'(sy_r) - (CODE_BITS+1)'(tcy);
  assign prod_x    = ex * ex;
  assign prod_y    = ey * ey;
  assign cand_dist = {1'b0, p2_sqx_r} + {1'b0, p2_sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= scan_en && cand_ok;
      p2_vld_r <= p1_vld_r;
    end
    p1_d_r   <= cand_d;
    p1_y_r   <= y_r;
    p2_d_r   <= p1_d_r;
    p2_y_r   <= p1_y_r;
    p2_sqx_r <= prod_x[SQ_W-1:0];
    p2_sqy_r <= prod_y[SQ_W-1:0];
  end

  // best so far; strict less-than keeps the first of equal distances
  logic                      found_r, found_nxt;
  logic [DIST_W-1:0]         best_r, best_nxt;
  logic signed [DISPX_W-1:0] bx_r, bx_nxt;
  logic signed [DY_W-1:0]    by_r, by_nxt;

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    bx_nxt    = bx_r;
    by_nxt    = by_r;
    if (acc_match) begin
      found_nxt = 1'b0;
    end else if (p2_vld_r && (!found_r || (cand_dist < best_r))) begin
      found_nxt = 1'b1;
      best_nxt  = cand_dist;
      bx_nxt    = p2_d_r;
      by_nxt    = p2_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) found_r <= 1'b0;
    else        found_r <= found_nxt;
    best_r <= best_nxt;
    bx_r   <= bx_nxt;
    by_r   <= by_nxt;
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                      hit;
  logic signed [DISPX_W-1:0] out_dx_r;
  logic signed [DY_W-1:0]    out_dy_r;
  logic                      out_hit_r;

  assign hit = found_r && (best_r <= DIST_W'(MATCH_LIMIT));

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_fire)          out_vld_nxt = 1'b1;
    else if (out_ch.ready) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= out_vld_nxt;
    if (out_fire) begin
      out_dx_r  <= hit ? bx_r : '0;
      out_dy_r  <= hit ? by_r : '0;
      out_hit_r <= hit;
    end
  end

  assign in_ch.ready    = in_rdy;
  assign out_ch.valid   = out_vld_r;
  assign out_ch.disp_x  = out_dx_r;
  assign out_ch.disp_y  = out_dy_r;
  assign out_ch.matched = out_hit_r;

endmodule
